@@ hdl/first_fit_heap_allocator_macros.svh @@
// Assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFHA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FFHA_ASSERT(lbl, prop, msg)
`define FFHA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ hdl/ffha_pkg.sv @@
package ffha_pkg;

  // block header size and smallest remainder worth splitting off
  localparam int HEADER_BYTES    = 12;
  localparam int MIN_SPLIT_BYTES = 4;

  // operation kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NO_FIT  = 2'd2;

endpackage

@@ hdl/first_fit_heap_allocator.sv @@
// First-fit heap allocator. The heap of HEAP_BYTES bytes (a power of two) is a chain of
// address-ordered blocks whose headers live in one single-port-read, one-port-write memory
// of HEAP_BYTES/4 words with a registered read. An item is taken only when the engine is idle
// and yields exactly one result beat. The chain walk visits one block per cycle through the
// memory read port: an allocate walks the chain, passes S_SPLIT for a split, then S_DONE;
// a free walks to the target, then merges in S_NEXT. A null or zero-size item skips the walk.
// After reset the S_INIT state writes the initial free header before the first item is taken.
// Configuration (heap_base) may be written at any time the block is idle.
`include "first_fit_heap_allocator_macros.svh"

module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: heap_base
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // request_size[15:0], free_address[47:16]
  input  logic        in_tuser,   // kind
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // payload_address, status, used_bytes, free_bytes, pad
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int DEPTH = HEAP_BYTES / 4;
  localparam int EW = AW + 1;
  localparam int CW = ((AW > 17) ? AW : 17) + 1;

  localparam logic [CW-1:0] HDR   = CW'(ffha_pkg::HEADER_BYTES);
  localparam logic [CW-1:0] SPLIT = CW'(ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_SPLIT_BYTES);
  localparam logic [CW-1:0] HEAP  = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] INIT_SIZE = CW'(HEAP_BYTES - ffha_pkg::HEADER_BYTES);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WALK  = 6'b000100,
    S_SPLIT = 6'b001000,
    S_NEXT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t         state_r, state_nxt;
  logic [31:0]    heap_base_r;
  logic           kind_r, kind_nxt;
  logic [CW-1:0]  off_r, off_nxt;
  logic [CW-1:0]  need_r, need_nxt;
  logic [31:0]    target_r, target_nxt;
  logic [CW-1:0]  prev_off_r, prev_off_nxt;
  logic [AW-1:0]  prev_size_r, prev_size_nxt;
  logic           prev_free_r, prev_free_nxt;
  logic           has_prev_r, has_prev_nxt;
  logic [AW-1:0]  cur_size_r, cur_size_nxt;
  logic           nx_valid_r, nx_valid_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [31:0]    addr_r, addr_nxt;
  logic [16:0]    used_r, used_nxt;
  logic [16:0]    free_r, free_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [71:0]    out_data_r;

  // header memory
  logic [EW-1:0]   mem [DEPTH];
  logic [EW-1:0]   rd_q;
  logic [AW-3:0]   rd_word;
  logic [AW-3:0]   wr_word;
  logic [EW-1:0]   wr_data;
  logic            mem_we;

  logic [AW-1:0]  dsize;
  logic           dfree;
  logic [CW-1:0]  nxt_off;
  logic [CW-1:0]  need_in;
  logic [CW-1:0]  rest_off;
  logic [CW-1:0]  rest_size;
  logic [CW-1:0]  merged;
  logic [CW-1:0]  prev_merged;
  logic           in_acc;
  logic           out_load;

  assign dsize     = rd_q[EW-1:1];
  assign dfree     = rd_q[0];
  assign nxt_off   = off_r + HDR + CW'(dsize);
  assign need_in   = (CW'(in_tdata[15:0]) + CW'(3)) & ~CW'(3);
  assign rest_off  = off_r + HDR + need_r;
  assign rest_size = CW'(dsize) - need_r - HDR;
  assign merged    = CW'(cur_size_r) + ((nx_valid_r && dfree) ? (HDR + CW'(dsize)) : '0);
  assign prev_merged = CW'(prev_size_r) + HDR + merged;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sequencer: reads one header per cycle, writes back merges and splits
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    off_nxt       = off_r;
    need_nxt      = need_r;
    target_nxt    = target_r;
    prev_off_nxt  = prev_off_r;
    prev_size_nxt = prev_size_r;
    prev_free_nxt = prev_free_r;
    has_prev_nxt  = has_prev_r;
    cur_size_nxt  = cur_size_r;
    nx_valid_nxt  = nx_valid_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    used_nxt      = used_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r;
    rd_word       = '0;
    wr_word       = '0;
    wr_data       = '0;
    mem_we        = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        wr_word   = '0;
        wr_data   = {INIT_SIZE[AW-1:0], 1'b1};
        used_nxt  = '0;
        free_nxt  = INIT_SIZE[16:0];
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt     = in_tuser;
          need_nxt     = need_in;
          target_nxt   = in_tdata[47:16] - heap_base_r - 32'(ffha_pkg::HEADER_BYTES);
          off_nxt      = '0;
          has_prev_nxt = 1'b0;
          addr_nxt     = '0;
          status_nxt   = ffha_pkg::ST_DONE;
          rd_word      = '0;
          if ((in_tuser == ffha_pkg::KIND_ALLOC && in_tdata[15:0] == 16'd0) ||
              (in_tuser == ffha_pkg::KIND_FREE && in_tdata[47:16] == 32'd0)) begin
            status_nxt = ffha_pkg::ST_IGNORED;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (kind_r == ffha_pkg::KIND_ALLOC) begin
          if (dfree && CW'(dsize) >= need_r) begin
            addr_nxt = heap_base_r + 32'(off_r) + 32'(ffha_pkg::HEADER_BYTES);
            mem_we   = 1'b1;
            if (CW'(dsize) >= need_r + SPLIT) begin
              // split: remainder becomes a free block with its header written now; the allocated header is written next
              wr_word   = rest_off[AW-1:2];
              wr_data   = {rest_size[AW-1:0], 1'b1};
              used_nxt  = used_r + 17'(need_r);
              free_nxt  = free_r - 17'(need_r + HDR);
              state_nxt = S_SPLIT;
            end else begin
              wr_word   = off_r[AW-1:2];
              wr_data   = {dsize, 1'b0};
              used_nxt  = used_r + 17'(dsize);
              free_nxt  = free_r - 17'(dsize);
              state_nxt = S_DONE;
            end
          end else if (nxt_off >= HEAP) begin
            status_nxt = ffha_pkg::ST_NO_FIT;
            state_nxt  = S_DONE;
          end else begin
            off_nxt = nxt_off;
            rd_word = nxt_off[AW-1:2];
          end
        end else begin
          if (32'(off_r) == target_r) begin
            // found: release it, then look at the following block
            cur_size_nxt = dsize;
            if (!dfree) begin
              used_nxt = used_r - 17'(dsize);
              free_nxt = free_r + 17'(dsize);
            end
            nx_valid_nxt = (nxt_off < HEAP);
            rd_word      = nxt_off[AW-1:2];
            state_nxt    = S_NEXT;
          end else begin
            prev_off_nxt  = off_r;
            prev_size_nxt = dsize;
            prev_free_nxt = dfree;
            has_prev_nxt  = 1'b1;
            if (nxt_off >= HEAP) begin
              status_nxt = ffha_pkg::ST_IGNORED;
              state_nxt  = S_DONE;
            end else begin
              off_nxt = nxt_off;
              rd_word = nxt_off[AW-1:2];
            end
          end
        end
      end
      S_SPLIT: begin
        mem_we    = 1'b1;
        wr_word   = off_r[AW-1:2];
        wr_data   = {need_r[AW-1:0], 1'b0};
        state_nxt = S_DONE;
      end
      S_NEXT: begin
        // coalesce with free neighbors; one header write covers both merges
        mem_we = 1'b1;
        if (has_prev_r && prev_free_r) begin
          wr_word  = prev_off_r[AW-1:2];
          wr_data  = {prev_merged[AW-1:0], 1'b1};
          free_nxt = free_r + 17'(HDR) + ((nx_valid_r && dfree) ? 17'(HDR) : 17'd0);
        end else begin
          wr_word  = off_r[AW-1:2];
          wr_data  = {merged[AW-1:0], 1'b1};
          free_nxt = free_r + ((nx_valid_r && dfree) ? 17'(HDR) : 17'd0);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // memory: a read that meets a write to the same entry returns old data and is never used
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_word] <= wr_data;
    end
    rd_q <= mem[rd_word];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      heap_base_r <= '0;
      used_r      <= '0;
      free_r      <= INIT_SIZE[16:0];
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        heap_base_r <= cfg_wdata;
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    off_r       <= off_nxt;
    need_r      <= need_nxt;
    target_r    <= target_nxt;
    prev_off_r  <= prev_off_nxt;
    prev_size_r <= prev_size_nxt;
    prev_free_r <= prev_free_nxt;
    has_prev_r  <= has_prev_nxt;
    cur_size_r  <= cur_size_nxt;
    nx_valid_r  <= nx_valid_nxt;
    status_r    <= status_nxt;
    addr_r      <= addr_nxt;
    if (out_load) begin
      out_data_r <= {4'b0, free_nxt, used_nxt, status_r, addr_r};
    end
  end

  `FFHA_ASSERT(a_no_write_idle, (state_r == S_IDLE) |-> !mem_we, "header write while idle")
  `FFHA_ASSERT(a_walk_in_heap, (state_r == S_WALK) |-> (off_r < HEAP), "walk left the heap")
  `FFHA_ASSERT_NEXT(a_accept_starts, in_acc, (state_r == S_WALK) || (state_r == S_DONE), "bad start")

endmodule
